// File: hdl/cssr_pkg.sv
// Shared types, constants and request/status codes for the slot record store.
// No dependencies; every other file in hdl/ uses this package.
package cssr_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int SLOT_BYTES_DEF = 2048;
  localparam int HDR_BYTES      = 6;
  localparam int CNT_W          = 16;

  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_WBYTE = 3'd1;
  localparam logic [2:0] REQ_VERIFY = 3'd2;
  localparam logic [2:0] REQ_RBYTE = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SLOT = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
  localparam logic [2:0] ST_LEN_MISM = 3'd4;
  localparam logic [2:0] ST_CHECKSUM = 3'd5;
  localparam logic [2:0] ST_NO_WRITE = 3'd6;
  localparam logic [2:0] ST_READ_REF = 3'd7;

  localparam logic [1:0] CFG_FIRST_MAGIC  = 2'd0;
  localparam logic [1:0] CFG_SECOND_MAGIC = 2'd1;
  localparam logic [1:0] CFG_VERSION      = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  slot;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic        match_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic [15:0] stored_length;
    logic        write_committed;
  } out_item_t;

  // Queue entry: the request plus the front's slot/length classification.
  typedef struct packed {
    in_item_t item;
    logic     bad_slot;
    logic     too_long;
  } q_entry_t;

endpackage

// File: hdl/cssr_ifs.sv
// Handshake interfaces for the request, result and register write channels.
// Depends on cssr_pkg.
interface cssr_in_if;
  logic               valid;
  logic               ready;
  cssr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cssr_out_if;
  logic                valid;
  logic                ready;
  cssr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cssr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/cssr_front.sv
// Request front end: accepts transactions, tags slot and length checks,
// and holds them in a two-entry queue for the engine. Depends on cssr_pkg.
module cssr_front #(
  parameter int SLOT_COUNT = cssr_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = cssr_pkg::SLOT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  cssr_in_if.sink             in_if,
  output logic                q_valid,
  input  logic                q_ready,
  output cssr_pkg::q_entry_t  q_entry
);

  localparam int PMAX = SLOT_BYTES - cssr_pkg::HDR_BYTES;

  cssr_pkg::q_entry_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  cssr_pkg::q_entry_t new_ent;

  assign in_if.ready = (cnt_r != 2'd2);
  assign push    = in_if.valid && in_if.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_entry = ent_r[rp_r];

  always_comb begin
    new_ent.item     = in_if.data;
    new_ent.bad_slot = (32'(in_if.data.slot) >= 32'(SLOT_COUNT));
    new_ent.too_long = (32'(in_if.data.length) > 32'(PMAX));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= new_ent;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hdl/cssr_engine.sv
// Back end: slot memory, write/verify state, header commit, verify walk,
// clear sweep and the result register. Depends on cssr_pkg and cssr_ifs.
module cssr_engine #(
  parameter int SLOT_COUNT = cssr_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = cssr_pkg::SLOT_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  cssr_pkg::q_entry_t q_entry,
  cssr_cfg_if.sink           cfg_if,
  cssr_out_if.source         out_if
);

  localparam int MEM_DEPTH = SLOT_COUNT * SLOT_BYTES;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int PMAX      = SLOT_BYTES - cssr_pkg::HDR_BYTES;
  localparam int CW        = cssr_pkg::CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDRW = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [7:0] mem [MEM_DEPTH];
  logic              we;
  logic [MEM_AW-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata_r;

  logic [2:0]  state_r;
  logic [7:0]  magic0_r, magic1_r, version_r;
  logic        wopen_r, vvalid_r;
  logic [7:0]  wslot_r, vslot_r;
  logic [15:0] wtarget_r, wpos_r, vlen_r, sl_r;
  logic [7:0]  wsum_r, vsum_r;
  logic [MEM_AW-1:0] wbase_r, vbase_r, base_r;
  logic [CW-1:0] cnt_r;
  logic        pend_r;
  logic [2:0]  lag_r;
  logic [7:0]  hdr_r [6];
  cssr_pkg::q_entry_t cur_r;
  cssr_pkg::out_item_t res_r, out_r;
  logic        out_valid_r;

  cssr_pkg::in_item_t it;
  logic [MEM_AW-1:0] qbase;
  logic [15:0] wpos_inc, hdr_len;
  logic        out_free;

  assign it       = q_entry.item;
  assign qbase    = MEM_AW'(32'(it.slot) * 32'(SLOT_BYTES));
  assign wpos_inc = wpos_r + 16'd1;
  assign hdr_len  = {hdr_r[4], hdr_r[3]};
  assign out_free = !out_valid_r || out_if.ready;
  assign q_ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = wbase_r;
    wdata = 8'd0;
    raddr = base_r + MEM_AW'(cnt_r);
    case (state_r)
      S_IDLE: begin
        if (q_valid && it.req_type == cssr_pkg::REQ_WBYTE && wopen_r) begin
          we    = 1'b1;
          waddr = wbase_r + MEM_AW'(cssr_pkg::HDR_BYTES) + MEM_AW'(wpos_r);
          wdata = it.data_byte;
        end
        raddr = vbase_r + MEM_AW'(cssr_pkg::HDR_BYTES) + MEM_AW'(it.byte_index);
      end
      S_HDRW: begin
        we    = 1'b1;
        waddr = wbase_r + MEM_AW'(cnt_r[2:0]);
        case (cnt_r[2:0])
          3'd0:    wdata = magic0_r;
          3'd1:    wdata = magic1_r;
          3'd2:    wdata = version_r;
          3'd3:    wdata = wtarget_r[7:0];
          3'd4:    wdata = wtarget_r[15:8];
          default: wdata = wsum_r;
        endcase
      end
      S_SUM: raddr = base_r + MEM_AW'(cssr_pkg::HDR_BYTES) + MEM_AW'(cnt_r);
      S_CLR: begin
        we    = 1'b1;
        waddr = base_r + MEM_AW'(cnt_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      magic0_r    <= 8'd0;
      magic1_r    <= 8'd0;
      version_r   <= 8'd0;
      wopen_r     <= 1'b0;
      wslot_r     <= 8'd0;
      wtarget_r   <= 16'd0;
      wpos_r      <= 16'd0;
      wsum_r      <= 8'd0;
      vvalid_r    <= 1'b0;
      vslot_r     <= 8'd0;
      vlen_r      <= 16'd0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.index)
          cssr_pkg::CFG_FIRST_MAGIC:  magic0_r  <= cfg_if.data;
          cssr_pkg::CFG_SECOND_MAGIC: magic1_r  <= cfg_if.data;
          cssr_pkg::CFG_VERSION:      version_r <= cfg_if.data;
          default: ;
        endcase
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r  <= q_entry;
            res_r  <= '0;
            base_r <= qbase;
            cnt_r  <= '0;
            pend_r <= 1'b0;
            state_r <= S_OUT;
            case (it.req_type)
              cssr_pkg::REQ_START: begin
                if (q_entry.bad_slot) begin
                  res_r.status <= cssr_pkg::ST_BAD_SLOT;
                end else if (q_entry.too_long) begin
                  res_r.status <= cssr_pkg::ST_TOO_LONG;
                end else begin
                  if (vvalid_r && vslot_r == it.slot) vvalid_r <= 1'b0;
                  wopen_r   <= 1'b1;
                  wslot_r   <= it.slot;
                  wtarget_r <= it.length;
                  wpos_r    <= 16'd0;
                  wsum_r    <= 8'd0;
                  wbase_r   <= qbase;
                  if (it.length == 16'd0) begin
                    res_r.write_committed <= 1'b1;
                    state_r <= S_HDRW;
                  end
                end
              end
              cssr_pkg::REQ_WBYTE: begin
                if (!wopen_r) begin
                  res_r.status <= cssr_pkg::ST_NO_WRITE;
                end else begin
                  wsum_r <= wsum_r + it.data_byte;
                  wpos_r <= wpos_inc;
                  if (wpos_inc >= wtarget_r) begin
                    res_r.write_committed <= 1'b1;
                    state_r <= S_HDRW;
                  end
                end
              end
              cssr_pkg::REQ_VERIFY: begin
                if (q_entry.bad_slot) begin
                  res_r.status <= cssr_pkg::ST_BAD_SLOT;
                end else begin
                  vvalid_r <= 1'b0;
                  state_r  <= S_WALK;
                end
              end
              cssr_pkg::REQ_RBYTE: begin
                if (!vvalid_r || it.slot != vslot_r || it.byte_index >= vlen_r) begin
                  res_r.status <= cssr_pkg::ST_READ_REF;
                end else begin
                  state_r <= S_RDW;
                end
              end
              cssr_pkg::REQ_CLEAR: begin
                if (q_entry.bad_slot) begin
                  res_r.status <= cssr_pkg::ST_BAD_SLOT;
                end else begin
                  state_r <= S_CLR;
                end
              end
              default: ;
            endcase
          end
        end
        S_HDRW: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[2:0] == 3'd5) begin
            wopen_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_WALK: begin
          // Header read: one address a cycle, data lands in the next cycle.
          if (cnt_r < CW'(cssr_pkg::HDR_BYTES)) begin
            cnt_r <= cnt_r + 1'b1;
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          lag_r <= cnt_r[2:0];
          if (pend_r) hdr_r[lag_r] <= rdata_r;
          if (cnt_r == CW'(cssr_pkg::HDR_BYTES) && !pend_r) begin
            res_r.stored_length <= hdr_len;
            sl_r   <= hdr_len;
            cnt_r  <= '0;
            vsum_r <= 8'd0;
            state_r <= S_OUT;
            if (hdr_r[0] != magic0_r || hdr_r[1] != magic1_r || hdr_r[2] != version_r) begin
              res_r.status <= cssr_pkg::ST_BAD_MAGIC;
            end else if (32'(hdr_len) > 32'(PMAX)) begin
              res_r.status <= cssr_pkg::ST_TOO_LONG;
            end else if (cur_r.item.match_length && hdr_len != cur_r.item.length) begin
              res_r.status <= cssr_pkg::ST_LEN_MISM;
            end else begin
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (cnt_r < sl_r) begin
            cnt_r <= cnt_r + 1'b1;
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) vsum_r <= vsum_r + rdata_r;
          if (cnt_r == sl_r && !pend_r) begin
            state_r <= S_OUT;
            if (vsum_r != hdr_r[5]) begin
              res_r.status <= cssr_pkg::ST_CHECKSUM;
            end else begin
              vvalid_r <= 1'b1;
              vslot_r  <= cur_r.item.slot;
              vlen_r   <= sl_r;
              vbase_r  <= base_r;
            end
          end
        end
        S_RDW: begin
          res_r.read_data <= rdata_r;
          state_r <= S_OUT;
        end
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (32'(cnt_r) == 32'(SLOT_BYTES - 1)) begin
            if (vvalid_r && vslot_r == cur_r.item.slot) vvalid_r <= 1'b0;
            if (wopen_r && wslot_r == cur_r.item.slot) wopen_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_wslot: assert property (@(posedge clk) disable iff (!rst_n)
    wopen_r |-> (32'(wslot_r) < 32'(SLOT_COUNT))) else $error("open write on bad slot");
  a_vlen: assert property (@(posedge clk) disable iff (!rst_n)
    vvalid_r |-> (32'(vlen_r) <= 32'(PMAX))) else $error("verified length too large");
  a_hdrw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HDRW) |-> (cnt_r < CW'(cssr_pkg::HDR_BYTES))) else $error("header overrun");
  a_wpos: assert property (@(posedge clk) disable iff (!rst_n)
    wopen_r |-> (wpos_r <= wtarget_r)) else $error("write position past target");
`endif

endmodule

// File: hdl/checksummed_slot_record_store_unit.sv
// Each request runs to its result on its own: a write byte that completes the record
// also writes the header; verify reads the header and, unless it fails, sums the
// stored payload; clear writes every byte of the slot. One request in the engine at a
// time; a new one is taken only after the last result moved into the result register,
// with a two-entry request queue in front. Reset (rst_n, synchronous) clears control
// state, format registers and queue pointers; data registers and slot memory are kept.
module checksummed_slot_record_store_unit #(
  parameter int SLOT_COUNT = cssr_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = cssr_pkg::SLOT_BYTES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  cssr_in_if.sink     in_if,
  cssr_out_if.source  out_if,
  cssr_cfg_if.sink    cfg_if
);

  logic               q_valid, q_ready;
  cssr_pkg::q_entry_t q_entry;

  cssr_front #(.SLOT_COUNT(SLOT_COUNT), .SLOT_BYTES(SLOT_BYTES)) u_front (
    .clk, .rst_n, .in_if, .q_valid, .q_ready, .q_entry
  );

  cssr_engine #(.SLOT_COUNT(SLOT_COUNT), .SLOT_BYTES(SLOT_BYTES)) u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_entry, .cfg_if, .out_if
  );

endmodule

// File: dv/cssr_tb_ifs.sv
`timescale 1ns / 1ps
// Testbench-side types for the directed table: the RTL interfaces in
// hdl/cssr_ifs.sv are used as they are. Depends on cssr_pkg.
package cssr_tb_types;

  // one row of the directed table; exp is used only when typed is set
  typedef struct packed {
    cssr_pkg::in_item_t  req;
    logic                typed;
    cssr_pkg::out_item_t exp;
  } dir_row_t;
endpackage

// File: dv/tb_checksummed_slot_record_store_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the slot record store: directed table, then
// random request sequences, checked by an in-bench predictor; typed rows
// by fixed results. Depends on cssr_pkg, cssr_ifs (hdl) and cssr_tb_types.
module tb_checksummed_slot_record_store_unit;

  localparam int NSLOT   = cssr_pkg::SLOT_COUNT_DEF;
  localparam int SBYTES  = cssr_pkg::SLOT_BYTES_DEF;
  localparam int HDR     = cssr_pkg::HDR_BYTES;
  localparam int MEMSZ   = NSLOT * SBYTES;
  localparam int PAY_MAX = SBYTES - HDR;
  localparam int STALL_LIMIT = 30000;
  localparam int DRAIN_CYCLES = SBYTES + 100;

  logic clk;
  logic rst_n;

  cssr_in_if  in_ch ();
  cssr_out_if out_ch ();
  cssr_cfg_if cfg_ch ();

  checksummed_slot_record_store_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  // predictor state
  logic [7:0]  rec_mem [0:MEMSZ-1];
  logic [7:0]  magic0, magic1, fmt_ver;
  logic        wr_open;
  logic [7:0]  wr_slot;
  logic [15:0] wr_len, wr_pos;
  logic [7:0]  wr_sum;
  logic        ver_ok;
  logic [7:0]  ver_slot;
  logic [15:0] ver_len;

  cssr_pkg::out_item_t results_due[$];
  int        errors;
  int        sent;
  int        in_idle, out_idle;
  int        hold_cycles;
  int        quiet_cycles;
  logic      cur_typed;
  cssr_pkg::out_item_t cur_exp;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void commit_record();
    int b;
    b = wr_slot * SBYTES;
    rec_mem[b]   = magic0;
    rec_mem[b+1] = magic1;
    rec_mem[b+2] = fmt_ver;
    rec_mem[b+3] = wr_len[7:0];
    rec_mem[b+4] = wr_len[15:8];
    rec_mem[b+5] = wr_sum;
    wr_open = 1'b0;
  endfunction

  function automatic cssr_pkg::out_item_t store_result(input cssr_pkg::in_item_t r);
    cssr_pkg::out_item_t o;
    int          b;
    logic [15:0] sl;
    logic [7:0]  sum;
    o = '0;
    b = r.slot * SBYTES;
    case (r.req_type)
      cssr_pkg::REQ_START: begin
        if (r.slot >= NSLOT) o.status = cssr_pkg::ST_BAD_SLOT;
        else if (r.length > PAY_MAX) o.status = cssr_pkg::ST_TOO_LONG;
        else begin
          if (ver_ok && ver_slot == r.slot) ver_ok = 1'b0;
          wr_open = 1'b1;
          wr_slot = r.slot;
          wr_len  = r.length;
          wr_pos  = '0;
          wr_sum  = '0;
          if (r.length == 16'd0) begin
            commit_record();
            o.write_committed = 1'b1;
          end
        end
      end
      cssr_pkg::REQ_WBYTE: begin
        if (!wr_open) o.status = cssr_pkg::ST_NO_WRITE;
        else begin
          rec_mem[wr_slot * SBYTES + HDR + wr_pos] = r.data_byte;
          wr_sum = wr_sum + r.data_byte;
          wr_pos = wr_pos + 16'd1;
          if (wr_pos >= wr_len) begin
            commit_record();
            o.write_committed = 1'b1;
          end
        end
      end
      cssr_pkg::REQ_VERIFY: begin
        if (r.slot >= NSLOT) o.status = cssr_pkg::ST_BAD_SLOT;
        else begin
          sl = {rec_mem[b+4], rec_mem[b+3]};
          o.stored_length = sl;
          ver_ok = 1'b0;
          if (rec_mem[b] != magic0 || rec_mem[b+1] != magic1 || rec_mem[b+2] != fmt_ver)
            o.status = cssr_pkg::ST_BAD_MAGIC;
          else if (sl > PAY_MAX) o.status = cssr_pkg::ST_TOO_LONG;
          else if (r.match_length && sl != r.length) o.status = cssr_pkg::ST_LEN_MISM;
          else begin
            sum = '0;
            for (int i = 0; i < sl; i++) sum = sum + rec_mem[b + HDR + i];
            if (sum != rec_mem[b+5]) o.status = cssr_pkg::ST_CHECKSUM;
            else begin
              ver_ok   = 1'b1;
              ver_slot = r.slot;
              ver_len  = sl;
            end
          end
        end
      end
      cssr_pkg::REQ_RBYTE: begin
        if (!ver_ok || r.slot != ver_slot || r.byte_index >= ver_len)
          o.status = cssr_pkg::ST_READ_REF;
        else o.read_data = rec_mem[ver_slot * SBYTES + HDR + r.byte_index];
      end
      cssr_pkg::REQ_CLEAR: begin
        if (r.slot >= NSLOT) o.status = cssr_pkg::ST_BAD_SLOT;
        else begin
          for (int i = 0; i < SBYTES; i++) rec_mem[b + i] = 8'h00;
          if (ver_ok && ver_slot == r.slot) ver_ok = 1'b0;
          if (wr_open && wr_slot == r.slot) wr_open = 1'b0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // transaction monitor: check results, then predict accepted requests
  always @(posedge clk) begin
    cssr_pkg::out_item_t want;
    cssr_pkg::out_item_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_ch.data);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_ch.data !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_ch.data);
            errors++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          cssr_pkg::CFG_FIRST_MAGIC:  magic0 = cfg_ch.data;
          cssr_pkg::CFG_SECOND_MAGIC: magic1 = cfg_ch.data;
          cssr_pkg::CFG_VERSION:      fmt_ver = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = store_result(in_ch.data);
        results_due.push_back(cur_typed ? cur_exp : pred);
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= out_idle);
    end
  end

  task automatic send_req(input cssr_pkg::in_item_t r, input logic typed,
                          input cssr_pkg::out_item_t exp);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = r;
    cur_typed   = typed;
    cur_exp     = exp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic rand_req(input logic [2:0] kind, input logic [7:0] slot,
                          input logic [15:0] len, input logic [15:0] idx);
    cssr_pkg::in_item_t r;
    r.req_type     = kind;
    r.slot         = slot;
    r.length       = len;
    r.data_byte    = 8'($urandom_range(255));
    r.byte_index   = idx;
    r.match_length = 1'($urandom_range(1));
    send_req(r, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_format(input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] v);
    drain();
    write_reg(cssr_pkg::CFG_FIRST_MAGIC, m0);
    write_reg(cssr_pkg::CFG_SECOND_MAGIC, m1);
    write_reg(cssr_pkg::CFG_VERSION, v);
  endtask

  // mostly complete records (start, bytes, verify, reads), the rest noise
  task automatic random_phase(input int count);
    int          stop_at;
    int          n;
    logic [7:0]  s;
    logic [15:0] len;
    logic [2:0]  kind;
    stop_at = sent + count;
    while (sent < stop_at) begin
      if ($urandom_range(99) < 70) begin
        s   = 8'($urandom_range(NSLOT - 1));
        len = 16'(($urandom_range(99) < 4) ? $urandom_range(600, 13) : $urandom_range(12));
        rand_req(cssr_pkg::REQ_START, s, len, 16'($urandom_range(65535)));
        n = int'(len);
        if (n > 0 && $urandom_range(9) == 0) n = int'($urandom_range(n - 1));
        for (int i = 0; i < n; i++)
          rand_req(cssr_pkg::REQ_WBYTE, 8'($urandom_range(255)), 16'd0, 16'd0);
        if ($urandom_range(9) == 0 && len > 0)
          rand_req(cssr_pkg::REQ_START, 8'($urandom_range(NSLOT - 1)), 16'd0, 16'd0);
        rand_req(cssr_pkg::REQ_VERIFY, s,
                 ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : len, 16'd0);
        n = int'($urandom_range(4));
        for (int i = 0; i < n; i++)
          rand_req(cssr_pkg::REQ_RBYTE,
                   ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : s, 16'd0,
                   16'(($urandom_range(4) == 0) ? $urandom_range(65535)
                                                : $urandom_range(len)));
      end else begin
        kind = 3'($urandom_range(7));
        if (kind == cssr_pkg::REQ_CLEAR && $urandom_range(9) != 0) kind = cssr_pkg::REQ_VERIFY;
        rand_req(kind,
                 8'($urandom_range(1) ? $urandom_range(255) : $urandom_range(NSLOT - 1)),
                 16'($urandom_range(65535)), 16'($urandom_range(65535)));
      end
    end
  endtask

  cssr_tb_types::dir_row_t dir_tbl[$];

  function automatic cssr_tb_types::dir_row_t row(input logic [2:0] kind, input int slot,
                                                  input int len, input int dat,
                                                  input int idx, input int match,
                                                  input int typed, input logic [2:0] st,
                                                  input int slen, input int cm);
    cssr_tb_types::dir_row_t d;
    d.req   = '{req_type: kind, slot: 8'(slot), length: 16'(len), data_byte: 8'(dat),
                byte_index: 16'(idx), match_length: 1'(match)};
    d.typed = (typed != 0);
    d.exp   = '{status: st, read_data: 8'h00, stored_length: 16'(slen),
                write_committed: 1'(cm)};
    return d;
  endfunction

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = cssr_pkg::CFG_FIRST_MAGIC;
    cfg_ch.data  = '0;
    rst_n = 1'b0;
    errors = 0;
    sent = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    cur_typed = 1'b0;
    cur_exp = '0;
    in_idle = 10;
    out_idle = 68;
    magic0 = '0; magic1 = '0; fmt_ver = '0;
    wr_open = 1'b0; wr_slot = '0; wr_len = '0; wr_pos = '0; wr_sum = '0;
    ver_ok = 1'b0; ver_slot = '0; ver_len = '0;
    for (int i = 0; i < MEMSZ; i++) rec_mem[i] = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // clear every slot first so no byte is ever read before it was written
    for (int s = 0; s < NSLOT; s++)
      dir_tbl.push_back(row(cssr_pkg::REQ_CLEAR, s, 0, 0, 0, 0, 1, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_CLEAR, 255, 0, 0, 0, 0, 1,
                          cssr_pkg::ST_BAD_SLOT, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_VERIFY, NSLOT, 0, 0, 0, 0, 1,
                          cssr_pkg::ST_BAD_SLOT, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_WBYTE, 0, 0, 255, 0, 0, 1,
                          cssr_pkg::ST_NO_WRITE, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_RBYTE, 0, 0, 0, 0, 0, 1,
                          cssr_pkg::ST_READ_REF, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_START, 0, PAY_MAX + 1, 0, 0, 0, 1,
                          cssr_pkg::ST_TOO_LONG, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_START, 0, PAY_MAX, 0, 0, 0, 1, cssr_pkg::ST_OK, 0, 0));
    // empty write drops the open one and commits at once
    dir_tbl.push_back(row(cssr_pkg::REQ_START, 1, 0, 0, 0, 0, 1, cssr_pkg::ST_OK, 0, 1));
    dir_tbl.push_back(row(cssr_pkg::REQ_WBYTE, 0, 0, 18, 0, 0, 1,
                          cssr_pkg::ST_NO_WRITE, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_VERIFY, 1, 0, 0, 0, 1, 1, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_START, 2, 3, 0, 0, 0, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_WBYTE, 0, 0, 255, 0, 0, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_WBYTE, 0, 0, 255, 0, 0, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_WBYTE, 0, 0, 0, 0, 0, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_VERIFY, 2, 3, 0, 0, 1, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_RBYTE, 2, 0, 0, 1, 0, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_RBYTE, 2, 0, 0, 3, 0, 1,
                          cssr_pkg::ST_READ_REF, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_VERIFY, 2, 65535, 0, 0, 1, 1,
                          cssr_pkg::ST_LEN_MISM, 3, 0));
    // partial rewrite leaves the old header, so the checksum breaks
    dir_tbl.push_back(row(cssr_pkg::REQ_START, 2, 3, 0, 0, 0, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_WBYTE, 0, 0, 1, 0, 0, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_CLEAR, 3, 0, 0, 0, 0, 0, cssr_pkg::ST_OK, 0, 0));
    dir_tbl.push_back(row(cssr_pkg::REQ_VERIFY, 2, 0, 0, 0, 0, 1,
                          cssr_pkg::ST_CHECKSUM, 3, 0));
    dir_tbl.push_back(row(3'd7, 255, 65535, 255, 65535, 1, 1, cssr_pkg::ST_OK, 0, 0));

    set_format(8'h00, 8'h00, 8'h00);
    foreach (dir_tbl[i]) send_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].exp);

    set_format(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    random_phase(500);

    set_format(8'hFF, 8'hFF, 8'hFF);
    in_idle = 68;
    out_idle = 10;
    random_phase(500);

    set_format(8'h00, 8'hFF, 8'h00);
    in_idle = 0;
    out_idle = 0;
    hold_cycles = 400;  // long receiver stall so the request queue backs up
    random_phase(525);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
